[hw/rtl/ddms_pkg.sv]
package ddms_pkg;

  // Digits the display is built for, and the room the output fields leave.
  localparam int NUM_DIGITS      = 4;
  localparam int FIELD_POSITIONS = 4;
  localparam int RADIX           = 10;

  localparam int DISP_W = (NUM_DIGITS > FIELD_POSITIONS) ? FIELD_POSITIONS :
                          (NUM_DIGITS < 1) ? 1 : NUM_DIGITS;

  function automatic int pow_radix(input int n);
    int p;
    p = 1;
    for (int i = 0; i < n; i++) begin
      p = p * RADIX;
    end
    return p;
  endfunction

  // Smallest value that no longer fits on the display.
  localparam int LIMIT = pow_radix(DISP_W);
  localparam int T_W   = $clog2(LIMIT);

  // Divide by ten as (t * 52429) >> 19, exact for t below 43690.
  localparam int RECIP_W     = 17;
  localparam int RECIP       = 52429;
  localparam int RECIP_SHIFT = 19;
  localparam int PROD_W      = T_W + RECIP_W;

  localparam int VALUE_W = 32;
  localparam int DIGIT_W = 4;
  localparam int POS_W   = 2;
  localparam int EN_W    = 4;

  typedef struct packed {
    logic load;
    logic divide;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic fits;
    logic last;
  } status_t;

endpackage

[hw/rtl/ddms_ctrl.sv]
module ddms_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  ddms_pkg::status_t status_i,
  output ddms_pkg::cmd_t   cmd_o
);
  import ddms_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SHOW
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          // Drop values too wide for the display right here.
          if (in_valid_i && in_ready_q && status_i.fits) begin
            state_q    <= ST_DIV;
            in_ready_q <= 1'b0;
          end
        end
        ST_DIV: begin
          state_q     <= ST_SHOW;
          out_valid_q <= 1'b1;
        end
        ST_SHOW: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            if (status_i.last) begin
              state_q    <= ST_IDLE;
              in_ready_q <= 1'b1;
            end else begin
              state_q <= ST_DIV;
            end
          end
        end
        default: begin
          state_q     <= ST_IDLE;
          in_ready_q  <= 1'b1;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o.load    = in_valid_i && in_ready_q;
    cmd_o.divide  = (state_q == ST_DIV);
    cmd_o.advance = (state_q == ST_SHOW) && out_ready_i && !status_i.last;
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule

[hw/rtl/ddms_datapath.sv]
module ddms_datapath (
  input  logic                          clk_i,
  input  ddms_pkg::cmd_t                cmd_i,
  output ddms_pkg::status_t             status_o,
  input  logic [ddms_pkg::VALUE_W-1:0]  value_i,
  output logic [ddms_pkg::DIGIT_W-1:0]  digit_bcd_o,
  output logic [ddms_pkg::POS_W-1:0]    position_o,
  output logic [ddms_pkg::EN_W-1:0]     enable_n_o,
  output logic                          is_last_o
);
  import ddms_pkg::*;

  logic [T_W-1:0]     t_q;
  logic [T_W-1:0]     q_q;
  logic [DIGIT_W-1:0] digit_q;
  logic [POS_W-1:0]   pos_q;

  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  prod_sh;
  logic [T_W-1:0]     quot;
  logic [T_W-1:0]     quot10;
  logic [T_W-1:0]     rem;

  always_comb begin
    prod    = PROD_W'(t_q) * PROD_W'(RECIP);
    prod_sh = prod >> RECIP_SHIFT;
    quot    = prod_sh[T_W-1:0];
    quot10  = T_W'({quot, 3'b000}) + T_W'({quot, 1'b0});
    rem     = t_q - quot10;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      t_q   <= value_i[T_W-1:0];
      pos_q <= '0;
    end else if (cmd_i.advance) begin
      t_q   <= q_q;
      pos_q <= pos_q + POS_W'(1);
    end
    if (cmd_i.divide) begin
      q_q     <= quot;
      digit_q <= rem[DIGIT_W-1:0];
    end
  end

  assign status_o.fits = (value_i < VALUE_W'(LIMIT));
  assign status_o.last = (q_q == '0);

  assign digit_bcd_o = digit_q;
  assign position_o  = pos_q;
  assign enable_n_o  = ~(EN_W'(1) << pos_q);
  assign is_last_o   = (q_q == '0);

endmodule

[hw/rtl/decimal_digit_mux_scanner.sv]
// Decimal digit scanner for a four-position multiplexed BCD display. Each
// value transferred in is split into decimal digits, least significant
// first, one result transfer per digit: the BCD digit, its position, an
// active-low one-hot position enable and is_last on the most significant
// digit. Zero shows as a single 0. A value with more digits than the display
// holds (10000 or more for four digits) is consumed and gives no results.
// Sequence: a value is loaded when it transfers in, then each digit takes a
// divide-by-ten step through the reciprocal multiplier and is then presented
// until its output transfer, which stalls while out_ready_i is low.
// Only one value is in flight; the input is ready again after the last digit
// transfers.
module decimal_digit_mux_scanner (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ddms_pkg::VALUE_W-1:0]  value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ddms_pkg::DIGIT_W-1:0]  digit_bcd_o,
  output logic [ddms_pkg::POS_W-1:0]    position_o,
  output logic [ddms_pkg::EN_W-1:0]     enable_n_o,
  output logic                          is_last_o
);
  import ddms_pkg::*;

  // Commands from the sequencer, status back from the digit datapath.
  cmd_t    cmd;
  status_t status;

  // Sequencer: load, divide, present, advance to the next digit.
  ddms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath: holds the running quotient, digit and position.
  ddms_datapath u_datapath (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .value_i     (value_i),
    .digit_bcd_o (digit_bcd_o),
    .position_o  (position_o),
    .enable_n_o  (enable_n_o),
    .is_last_o   (is_last_o)
  );

endmodule
